/* hdl/fci_pkg.sv */
// Shared constants, register codes and state type of the fan curve interpolator.
package fci_pkg;

  localparam int TEMP_W  = 8;
  localparam int PCT_W   = 7;
  localparam int DUTY_W  = 16;
  localparam int CFG_W   = 8;
  localparam int IDX_W   = 3;
  localparam int NPOINTS = 5;

  // Shared bit-serial multiplier: A is the wide operand, B is consumed one bit a cycle
  localparam int MUL_AW = DUTY_W;
  localparam int MUL_BW = TEMP_W;
  localparam int PROD_W = MUL_AW + MUL_BW;

  // Shared restoring divider
  localparam int DIV_NW = PROD_W;
  localparam int DIV_DW = TEMP_W;
  localparam int STEP_W = $clog2(DIV_NW + 1);

  // Significant product bits of each use, which set the divider step counts
  localparam int SEG_PROD_W  = PCT_W + TEMP_W;
  localparam int DUTY_PROD_W = DUTY_W + PCT_W;
  localparam logic [STEP_W-1:0] SEG_DIV_STEPS  = STEP_W'(SEG_PROD_W);
  localparam logic [STEP_W-1:0] DUTY_DIV_STEPS = STEP_W'(DUTY_PROD_W);

  localparam int unsigned DUTY_MAX_DEF = 255;

  localparam logic [PCT_W-1:0]  MIN_PCT   = 7'd25;
  localparam logic [PCT_W-1:0]  FULL_PCT  = 7'd100;
  localparam logic [DIV_DW-1:0] PCT_SCALE = 8'd100;

  typedef enum logic [IDX_W-1:0] {
    REG_P1_TEMP,
    REG_P2_TEMP,
    REG_P3_TEMP,
    REG_P4_TEMP,
    REG_P1_PCT,
    REG_P2_PCT,
    REG_P3_PCT,
    REG_P4_PCT
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SELECT,
    ST_MUL_SEG,
    ST_DIV_SEG,
    ST_CLAMP,
    ST_MUL_DUTY,
    ST_DIV_DUTY,
    ST_SEND
  } state_e;

endpackage

/* hdl/fci_serial_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, MSB first.
module fci_serial_mul import fci_pkg::*; #(
  parameter int AW = MUL_AW,
  parameter int BW = MUL_BW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic [AW+BW-1:0] prod_o,
  output logic            done_o
);

  localparam int CntW = $clog2(BW + 1);

  logic [AW-1:0]    a_q, a_d;
  logic [BW-1:0]    b_q, b_d;
  logic [AW+BW-1:0] acc_q, acc_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  // Load operands on start, then double and add once per multiplier bit
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
      cnt_d  = CntW'(BW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {acc_q[AW+BW-2:0], 1'b0} + (b_q[BW-1] ? {{BW{1'b0}}, a_q} : '0);
      b_d   = {b_q[BW-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

/* hdl/fci_serial_div.sv */
// Restoring divider, one quotient bit per cycle over a left-aligned dividend.
module fci_serial_div import fci_pkg::*; #(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NW-1:0]     dividend_i,
  input  logic [DW-1:0]     divisor_i,
  input  logic [STEP_W-1:0] steps_i,
  output logic [NW-1:0]     quot_o,
  output logic              done_o
);

  logic [NW-1:0]     q_q, q_d;
  logic [DW-1:0]     r_q, r_d;
  logic [DW-1:0]     dvs_q, dvs_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DW:0]       rem_sh;
  logic [DW:0]       rem_sub;
  logic              fits;

  // Shift one dividend bit into the remainder and try the subtract
  always_comb begin
    rem_sh  = {r_q, q_q[NW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = rem_sh >= {1'b0, dvs_q};
  end

  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      q_d    = dividend_i;
      r_d    = '0;
      dvs_d  = divisor_i;
      cnt_d  = steps_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      q_d   = {q_q[NW-2:0], fits};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    r_q   <= r_d;
    dvs_q <= dvs_d;
  end

  assign quot_o = q_q;
  assign done_o = done_q;

endmodule

/* hdl/fan_curve_interpolator.sv */
// Top level of the fan curve interpolator: config registers, segment select and sequencer.
// Each word runs through the bit-serial multiplier (8 steps) and the restoring divider
// (15 steps for the segment, 23 steps for the duty scale); at full speed or on a
// zero-width segment the segment pass is skipped and only the duty scale runs.
// A new word is taken only after the last result is loaded into a free output register. Reset
// clears control state and last percent and loads the default curve.
module fan_curve_interpolator import fci_pkg::*; #(
  parameter int unsigned DUTY_MAX = DUTY_MAX_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,  // [8:0] temp_celsius, rest zero
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata   // [6:0] fan_percent, [14:7] duty_value,
                                          // [15] speed_changed
);

  localparam logic [DUTY_W-1:0] DutyMaxC = DUTY_W'(DUTY_MAX);

  state_e state_q, state_d;

  logic [TEMP_W-1:0] pt_temp_q [NPOINTS-1];
  logic [PCT_W-1:0]  pt_pct_q  [NPOINTS-1];

  logic [TEMP_W-1:0] bp_temp [NPOINTS];
  logic [PCT_W-1:0]  bp_pct  [NPOINTS];

  logic [TEMP_W-1:0] t_in;
  logic              found;
  logic              full_d, zero_d;
  logic [PCT_W-1:0]  plo_d, phi_d;
  logic [TEMP_W-1:0] dt_d, w_d;

  logic              full_q, zero_q;
  logic [PCT_W-1:0]  plo_q, phi_q;
  logic [TEMP_W-1:0] dt_q, w_q;

  logic              dp_neg;
  logic [PCT_W-1:0]  dp_mag;

  logic [PCT_W-1:0]  pct_q, pct_d;
  logic [PCT_W-1:0]  last_q;
  logic signed [PCT_W+1:0] psum;

  logic              m_valid_q, m_valid_d;
  logic [15:0]       m_data_q;
  logic              load_out;
  logic              in_accept;

  logic              mul_start, mul_done;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [PROD_W-1:0] prod;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [STEP_W-1:0] div_steps;
  logic [DIV_NW-1:0] quot;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_temp_q[0] <= 8'd40;
      pt_temp_q[1] <= 8'd60;
      pt_temp_q[2] <= 8'd70;
      pt_temp_q[3] <= 8'd80;
      pt_pct_q[0]  <= 7'd25;
      pt_pct_q[1]  <= 7'd50;
      pt_pct_q[2]  <= 7'd70;
      pt_pct_q[3]  <= 7'd100;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_P1_TEMP: pt_temp_q[0] <= cfg_wdata_i;
        REG_P2_TEMP: pt_temp_q[1] <= cfg_wdata_i;
        REG_P3_TEMP: pt_temp_q[2] <= cfg_wdata_i;
        REG_P4_TEMP: pt_temp_q[3] <= cfg_wdata_i;
        REG_P1_PCT:  pt_pct_q[0]  <= cfg_wdata_i[PCT_W-1:0];
        REG_P2_PCT:  pt_pct_q[1]  <= cfg_wdata_i[PCT_W-1:0];
        REG_P3_PCT:  pt_pct_q[2]  <= cfg_wdata_i[PCT_W-1:0];
        REG_P4_PCT:  pt_pct_q[3]  <= cfg_wdata_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Breakpoint list with the fixed origin in front
  always_comb begin
    bp_temp[0] = '0;
    bp_pct[0]  = '0;
    for (int i = 1; i < NPOINTS; i++) begin
      bp_temp[i] = pt_temp_q[i-1];
      bp_pct[i]  = pt_pct_q[i-1];
    end
  end

  // Clamp negative input to zero and pick the first segment that holds it
  always_comb begin
    t_in   = s_axis_tdata[8] ? '0 : s_axis_tdata[TEMP_W-1:0];
    found  = 1'b0;
    zero_d = 1'b0;
    plo_d  = '0;
    phi_d  = '0;
    dt_d   = '0;
    w_d    = '0;
    for (int i = 0; i < NPOINTS - 1; i++) begin
      if (!found && t_in >= bp_temp[i] && t_in <= bp_temp[i+1]) begin
        found  = 1'b1;
        zero_d = bp_temp[i] == bp_temp[i+1];
        plo_d  = bp_pct[i];
        phi_d  = bp_pct[i+1];
        dt_d   = t_in - bp_temp[i];
        w_d    = bp_temp[i+1] - bp_temp[i];
      end
    end
    full_d = (t_in >= bp_temp[NPOINTS-1]) || !found;
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Hold the selected segment for the arithmetic
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      full_q <= full_d;
      zero_q <= zero_d;
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      dt_q   <= dt_d;
      w_q    <= w_d;
    end
  end

  // Percent step across the segment as sign and magnitude
  always_comb begin
    dp_neg = phi_q < plo_q;
    dp_mag = dp_neg ? plo_q - phi_q : phi_q - plo_q;
  end

  // Combine base percent with the truncated quotient (upper percent on a zero-width segment), then apply the limits
  always_comb begin
    if (zero_q) begin
      psum = {2'b00, phi_q};
    end else if (dp_neg) begin
      psum = {2'b00, plo_q} - {2'b00, quot[PCT_W-1:0]};
    end else begin
      psum = {2'b00, plo_q} + {2'b00, quot[PCT_W-1:0]};
    end
    if (full_q) begin
      pct_d = FULL_PCT;
    end else if (psum < $signed({2'b00, MIN_PCT})) begin
      pct_d = '0;
    end else if (psum > $signed({2'b00, FULL_PCT})) begin
      pct_d = FULL_PCT;
    end else begin
      pct_d = psum[PCT_W-1:0];
    end
  end

  // Sequencer: next state and unit starts
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    mul_a         = {{(MUL_AW-PCT_W){1'b0}}, dp_mag};
    mul_b         = dt_q;
    div_num       = {prod[SEG_PROD_W-1:0], {(DIV_NW-SEG_PROD_W){1'b0}}};
    div_den       = w_q;
    div_steps     = SEG_DIV_STEPS;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = ST_SELECT;
        end
      end
      ST_SELECT: begin
        if (full_q || zero_q) begin
          state_d = ST_CLAMP;
        end else begin
          mul_start = 1'b1;
          state_d   = ST_MUL_SEG;
        end
      end
      ST_MUL_SEG: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV_SEG;
        end
      end
      ST_DIV_SEG: begin
        if (div_done) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        mul_a     = DutyMaxC;
        mul_b     = {{(MUL_BW-PCT_W){1'b0}}, pct_d};
        mul_start = 1'b1;
        state_d   = ST_MUL_DUTY;
      end
      ST_MUL_DUTY: begin
        div_num   = {prod[DUTY_PROD_W-1:0], {(DIV_NW-DUTY_PROD_W){1'b0}}};
        div_den   = PCT_SCALE;
        div_steps = DUTY_DIV_STEPS;
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV_DUTY;
        end
      end
      ST_DIV_DUTY: begin
        if (div_done) begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the final percent once the curve value is known
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLAMP) begin
      pct_q <= pct_d;
    end
  end

  // Output register: drop valid when taken, load a new word when free
  always_comb begin
    m_valid_d = m_valid_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (load_out) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      last_q    <= '0;
    end else begin
      m_valid_q <= m_valid_d;
      if (load_out) begin
        last_q <= pct_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {pct_q != last_q, quot[7:0], pct_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  fci_serial_mul #(
    .AW(MUL_AW),
    .BW(MUL_BW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod),
    .done_o (mul_done)
  );

  fci_serial_div #(
    .NW(DIV_NW),
    .DW(DIV_DW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .steps_i   (div_steps),
    .quot_o    (quot),
    .done_o    (div_done)
  );

endmodule
